@@ design/sync_crc16_frame_receiver_macros.svh @@
// assertion macros shared by the frame receiver modules
// each macro expects clk and rst_n in the scope where it is used
`ifndef SYNC_CRC16_FRAME_RECEIVER_MACROS_SVH
`define SYNC_CRC16_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// next-cycle implication, disabled during reset
`define SRX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

@@ design/srx_pkg.sv @@
// types, constants and the byte-wide crc update for the frame receiver
// no dependencies
package srx_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [3:0]  PAYLOAD_LEN = 4'd13;
    localparam logic [3:0]  LAST_IDX    = 4'd14;

    localparam logic [7:0] FIRST_SYNC_RESET  = 8'hAA;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'h55;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'b1;

    localparam int ITEM_QUEUE_DEPTH   = 4;
    localparam int RESULT_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PHASE_HUNT    = 2'd0,
        PHASE_SYNC2   = 2'd1,
        PHASE_COLLECT = 2'd2
    } srx_phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CRC_LO  = 2'd1,
        KIND_CRC_HI  = 2'd2
    } srx_kind_t;

    // one classified frame byte from front to back
    typedef struct packed {
        srx_kind_t   kind;
        logic [3:0]  idx;
        logic [7:0]  data;
    } srx_item_t;

    typedef struct packed {
        logic        crc_ok;
        logic [7:0]  frame_id;
        logic [31:0] forward_step_bits;
        logic [31:0] yaw_step_bits;
        logic [31:0] depth_target_bits;
    } srx_result_t;

    // crc-16/ccitt-false, one byte msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

@@ design/srx_fifo.sv @@
// small register queue used between front and back and for results
// depends on sync_crc16_frame_receiver_macros.svh
`include "sync_crc16_frame_receiver_macros.svh"

module srx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    `SRX_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

@@ design/srx_front.sv @@
// front end: sync hunt, byte counting and classification of frame bytes
// depends on srx_pkg
module srx_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          push,
    input  logic [7:0]                    rx_byte,
    output logic                          full,
    output logic                          q_push,
    output srx_pkg::srx_item_t            q_item,
    input  logic                          q_full
);

    srx_pkg::srx_phase_t phase_reg, phase_next;
    logic [3:0]          count_reg, count_next;
    logic [7:0]          first_sync_reg, second_sync_reg;
    logic                accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= srx_pkg::FIRST_SYNC_RESET;
            second_sync_reg <= srx_pkg::SECOND_SYNC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srx_pkg::CFG_FIRST_SYNC:  first_sync_reg  <= cfg_data;
                srx_pkg::CFG_SECOND_SYNC: second_sync_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= srx_pkg::PHASE_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        q_push      = 1'b0;
        q_item.data = rx_byte;
        q_item.idx  = count_reg;
        if (count_reg < srx_pkg::PAYLOAD_LEN)
            q_item.kind = srx_pkg::KIND_PAYLOAD;
        else if (count_reg == srx_pkg::LAST_IDX)
            q_item.kind = srx_pkg::KIND_CRC_HI;
        else
            q_item.kind = srx_pkg::KIND_CRC_LO;

        if (accept)
        begin
            case (phase_reg)
                srx_pkg::PHASE_HUNT:
                begin
                    if (rx_byte == first_sync_reg)
                        phase_next = srx_pkg::PHASE_SYNC2;
                end
                srx_pkg::PHASE_SYNC2:
                begin
                    // a failed second sync is not looked at again as a first sync
                    if (rx_byte == second_sync_reg)
                    begin
                        phase_next = srx_pkg::PHASE_COLLECT;
                        count_next = '0;
                    end
                    else
                        phase_next = srx_pkg::PHASE_HUNT;
                end
                srx_pkg::PHASE_COLLECT:
                begin
                    q_push = 1'b1;
                    if (count_reg == srx_pkg::LAST_IDX)
                    begin
                        phase_next = srx_pkg::PHASE_HUNT;
                        count_next = '0;
                    end
                    else
                        count_next = count_reg + 1'b1;
                end
                default:
                begin
                    phase_next = srx_pkg::PHASE_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

endmodule

@@ design/srx_back.sv @@
// back end: crc update, frame byte store, crc check and field latching
// depends on srx_pkg and sync_crc16_frame_receiver_macros.svh
`include "sync_crc16_frame_receiver_macros.svh"

module srx_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  srx_pkg::srx_item_t   q_item,
    output logic                 q_pop,
    output logic                 res_push,
    output srx_pkg::srx_result_t res,
    input  logic                 res_full
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  pend_reg [14];
    logic [7:0]  held_id_reg, held_id_next;
    logic [31:0] held_fwd_reg, held_fwd_next;
    logic [31:0] held_yaw_reg, held_yaw_next;
    logic [31:0] held_depth_reg, held_depth_next;
    logic        is_last, crc_match;
    logic [15:0] crc_base;

    assign is_last   = (q_item.kind == srx_pkg::KIND_CRC_HI);
    // the last byte waits only while the result queue is full
    assign q_pop     = !q_empty && (!is_last || !res_full);
    assign res_push  = q_pop && is_last;
    assign crc_match = ({q_item.data, pend_reg[13]} == crc_reg);
    assign crc_base  = (q_item.idx == '0) ? srx_pkg::CRC_INIT : crc_reg;

    always_comb
    begin
        crc_next        = crc_reg;
        held_id_next    = held_id_reg;
        held_fwd_next   = held_fwd_reg;
        held_yaw_next   = held_yaw_reg;
        held_depth_next = held_depth_reg;
        if (q_pop && q_item.kind == srx_pkg::KIND_PAYLOAD)
            crc_next = srx_pkg::crc16_byte(crc_base, q_item.data);
        if (res_push && crc_match)
        begin
            held_id_next    = pend_reg[0];
            held_fwd_next   = {pend_reg[4], pend_reg[3], pend_reg[2], pend_reg[1]};
            held_yaw_next   = {pend_reg[8], pend_reg[7], pend_reg[6], pend_reg[5]};
            held_depth_next = {pend_reg[12], pend_reg[11], pend_reg[10], pend_reg[9]};
        end
        res.crc_ok            = crc_match;
        res.frame_id          = held_id_next;
        res.forward_step_bits = held_fwd_next;
        res.yaw_step_bits     = held_yaw_next;
        res.depth_target_bits = held_depth_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= srx_pkg::CRC_INIT;
            held_id_reg    <= '0;
            held_fwd_reg   <= '0;
            held_yaw_reg   <= '0;
            held_depth_reg <= '0;
        end
        else
        begin
            crc_reg        <= crc_next;
            held_id_reg    <= held_id_next;
            held_fwd_reg   <= held_fwd_next;
            held_yaw_reg   <= held_yaw_next;
            held_depth_reg <= held_depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !is_last)
            pend_reg[q_item.idx] <= q_item.data;
    end

    `SRX_ASSERT_NOW(a_push_on_last, res_push, q_item.idx == srx_pkg::LAST_IDX)
    `SRX_ASSERT_NOW(a_no_push_when_full, res_full, !res_push)
    `SRX_ASSERT_NEXT(a_bad_crc_holds, res_push && !crc_match,
                     $stable(held_id_reg) && $stable(held_fwd_reg))

endmodule

@@ design/sync_crc16_frame_receiver.sv @@
// Sync-word framed byte receiver with CRC-16/CCITT-FALSE check. One byte is
// accepted per clock while full is low: the front end hunts for the two sync
// bytes and tags each following frame byte, a short queue hands the tagged
// bytes to the back end, which folds one byte a cycle into the crc and stores
// the frame. On the fifteenth frame byte one result is pushed into the result
// queue at the same edge that takes the byte from the internal queue, so each
// result passes the internal queue and then the result queue on its way to
// the result ports; results show the latched fields of the last good frame.
// full rises only when the internal queue backs up, which happens when the
// result queue is full and pop stays low. Sync bytes are written over the cfg
// port only while idle, a rule for the user that the block does not enforce.
// depends on srx_pkg, srx_fifo, srx_front and srx_back
module sync_crc16_frame_receiver #(
    parameter int ITEM_DEPTH   = srx_pkg::ITEM_QUEUE_DEPTH,
    parameter int RESULT_DEPTH = srx_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          push,
    input  logic [7:0]                    rx_byte,
    output logic                          full,
    input  logic                          pop,
    output logic                          empty,
    output logic                          crc_ok,
    output logic [7:0]                    frame_id,
    output logic [31:0]                   forward_step_bits,
    output logic [31:0]                   yaw_step_bits,
    output logic [31:0]                   depth_target_bits
);

    srx_pkg::srx_item_t   front_item, back_item;
    srx_pkg::srx_result_t back_res, out_res;
    logic                 q_push, q_full, q_pop, q_empty;
    logic                 res_push, res_full;

    srx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .q_push    (q_push),
        .q_item    (front_item),
        .q_full    (q_full)
    );

    srx_fifo #(
        .WIDTH ($bits(srx_pkg::srx_item_t)),
        .DEPTH (ITEM_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (back_item),
        .empty (q_empty)
    );

    srx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (back_item),
        .q_pop    (q_pop),
        .res_push (res_push),
        .res      (back_res),
        .res_full (res_full)
    );

    srx_fifo #(
        .WIDTH ($bits(srx_pkg::srx_result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign crc_ok            = out_res.crc_ok;
    assign frame_id          = out_res.frame_id;
    assign forward_step_bits = out_res.forward_step_bits;
    assign yaw_step_bits     = out_res.yaw_step_bits;
    assign depth_target_bits = out_res.depth_target_bits;

endmodule
